[rtl/rss_pkg.sv]
// Shared types and constants for the reservoir sampler.
package rss_pkg;

  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  localparam logic [0:0] CFG_SAMPLE_SIZE = 1'd0;
  localparam logic [0:0] CFG_SEED        = 1'd1;

  typedef struct packed {
    logic [31:0] item_value;
    logic        last_item;
  } rss_in_t;

  typedef struct packed {
    logic [31:0] sample_value;
    logic [5:0]  sample_slot;
    logic        last_sample;
  } rss_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_A_LO, ST_MUL_A_HI, ST_MUL_B_LO, ST_MUL_B_HI,
    ST_DIV, ST_WRITE, ST_EMIT_RD, ST_EMIT
  } rss_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take_item;   // latch item, load seed if stream start
    logic fill_write;  // store item in next free slot
    logic gen_step;    // advance generator, form premix
    logic mul_a_lo;
    logic mul_a_hi;
    logic mul_b_lo;
    logic mul_b_hi;
    logic div_start;
    logic div_step;
    logic repl_write;  // store item at quotient remainder if in range
    logic emit_start;
    logic emit_read;   // issue read of emit slot
    logic emit_out;    // present slot on output, advance
    logic rearm;
  } rss_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic fill_mode;   // fill count below size in use
    logic div_done;
    logic emit_any;    // at least one filled slot to emit
    logic emit_final;  // current emit slot is the last filled
  } rss_stat_t;

endpackage

[rtl/rss_ram.sv]
// Generic single-port-write, registered-read RAM.
module rss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write one word, register the read word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

[rtl/rss_ctrl.sv]
// Sequencing state machine for the reservoir sampler.
module rss_ctrl import rss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      last_item,
  input  rss_stat_t stat,
  output rss_cmd_t  cmd,
  output logic      busy
);

  rss_state_t state_r, state_nxt;
  logic       last_r, last_nxt;

  // Hold state and the last flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.take_item = 1'b1;
          last_nxt      = last_item;
          state_nxt     = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (stat.fill_mode) begin
          cmd.fill_write = 1'b1;
          state_nxt      = last_r ? ST_EMIT_RD : ST_IDLE;
          cmd.emit_start = last_r;
        end else begin
          cmd.gen_step = 1'b1;
          state_nxt    = ST_MUL_A_LO;
        end
      end
      ST_MUL_A_LO: begin
        cmd.mul_a_lo = 1'b1;
        state_nxt    = ST_MUL_A_HI;
      end
      ST_MUL_A_HI: begin
        cmd.mul_a_hi = 1'b1;
        state_nxt    = ST_MUL_B_LO;
      end
      ST_MUL_B_LO: begin
        cmd.mul_b_lo = 1'b1;
        state_nxt    = ST_MUL_B_HI;
      end
      ST_MUL_B_HI: begin
        cmd.mul_b_hi  = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.repl_write = 1'b1;
          cmd.emit_start = last_r;
          state_nxt      = last_r ? ST_EMIT_RD : ST_IDLE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_EMIT_RD: begin
        if (stat.emit_any) begin
          cmd.emit_read = 1'b1;
          state_nxt     = ST_EMIT;
        end else begin
          cmd.rearm = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        cmd.emit_out = 1'b1;
        if (stat.emit_final) begin
          cmd.rearm = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  // A result only appears while emitting.
  a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_out |-> state_r == ST_EMIT)
    else $error("emit outside emit state");
  // Accept only from idle; an accepted item makes the controller busy.
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_item |=> busy)
    else $error("item accept did not go busy");
  // Divider work only follows the second multiply.
  a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> $past(state_r) == ST_MUL_B_HI || $past(state_r) == ST_DIV)
    else $error("divider entered out of order");
`endif

endmodule

[rtl/rss_dp.sv]
// Datapath: generator, split multiplier, restoring divider, slot store.
module rss_dp import rss_pkg::*; #(
  parameter int SLOT_COUNT = 16,
  parameter int ITEM_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rss_cmd_t    cmd,
  output rss_stat_t   stat,
  input  rss_in_t     in_word,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  output rss_out_t    out_word
);

  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [6:0]  size_r;
  logic [63:0] seed_r;
  logic [CW-1:0] fill_r;
  logic [63:0] seen_r;
  logic [63:0] gen_r;
  logic [31:0] item_r;
  logic [63:0] z_r;    // value being mixed
  logic [63:0] acc_r;  // product being built
  logic [63:0] rem_r, quo_r, div_r;
  logic        wrap_r;
  logic [6:0]  div_cnt_r;
  logic [CW-1:0] emit_r;
  logic [CW-1:0] k_eff;
  logic [31:0] rd_data;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [64:0] rem_sh;
  logic [63:0] mul_src;
  logic [31:0] mul_b;
  logic [31:0] mul_bh;
  logic [63:0] mul_p;
  logic [63:0] j_val;
  logic [63:0] raw_r;

  // Saturate sample size at the built depth.
  assign k_eff = (size_r > 7'(SLOT_COUNT)) ? CW'(SLOT_COUNT) : CW'(size_r);

  assign stat.fill_mode  = (fill_r < k_eff);
  assign stat.div_done   = (div_cnt_r == 7'd64);
  assign stat.emit_any   = (emit_r < fill_r);
  assign stat.emit_final = (emit_r + CW'(1) == fill_r);

  // Config registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 7'd16;
      seed_r <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_SAMPLE_SIZE) size_r <= cfg_data[6:0];
      else                            seed_r <= cfg_data;
    end
  end

  // Build the 64-bit low product from 32x32 pieces: the low step forms
  // zl*ml, the high step adds the two cross terms shifted up 32 bits.
  assign mul_src = z_r;
  assign mul_b   = (cmd.mul_a_lo || cmd.mul_a_hi) ? MIX_MUL_A[31:0] : MIX_MUL_B[31:0];
  assign mul_bh  = (cmd.mul_a_lo || cmd.mul_a_hi) ? MIX_MUL_A[63:32] : MIX_MUL_B[63:32];
  assign mul_p   = (cmd.mul_a_lo || cmd.mul_b_lo) ?
                   {32'd0, mul_src[31:0]} * {32'd0, mul_b} :
                   {mul_src[31:0] * mul_bh + mul_src[63:32] * mul_b, 32'd0};

  // Restoring divider shift.
  assign rem_sh = {rem_r, quo_r[63]};

  // Control and arithmetic state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      seen_r    <= '0;
      gen_r     <= '0;
      div_cnt_r <= 7'd64;
      emit_r    <= '0;
    end else begin
      if (cmd.take_item) begin
        item_r <= in_word.item_value & 32'((65'd1 << ITEM_BITS) - 65'd1);
        if (seen_r == 64'd0) gen_r <= seed_r;
      end
      if (cmd.fill_write) begin
        fill_r <= fill_r + CW'(1);
        seen_r <= seen_r + 64'd1;
      end
      if (cmd.gen_step) begin
        gen_r <= gen_r + GOLDEN_STEP;
        z_r   <= (gen_r + GOLDEN_STEP) ^ ((gen_r + GOLDEN_STEP) >> 30);
      end
      if (cmd.mul_a_lo || cmd.mul_b_lo) acc_r <= mul_p;
      if (cmd.mul_a_hi) z_r <= (acc_r + mul_p) ^ ((acc_r + mul_p) >> 27);
      if (cmd.mul_b_hi) begin
        div_r  <= seen_r + 64'd1;
        wrap_r <= (seen_r + 64'd1 == 64'd0);
        quo_r  <= (acc_r + mul_p) ^ ((acc_r + mul_p) >> 31);
        rem_r  <= '0;
      end
      if (cmd.div_start) div_cnt_r <= '0;
      if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + 7'd1;
        if (rem_sh >= {1'b0, div_r}) begin
          rem_r <= 64'(rem_sh - {1'b0, div_r});
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= rem_sh[63:0];
          quo_r <= {quo_r[62:0], 1'b0};
        end
      end
      if (cmd.repl_write) seen_r <= seen_r + 64'd1;
      if (cmd.emit_start) emit_r <= '0;
      if (cmd.emit_out)   emit_r <= emit_r + CW'(1);
      if (cmd.rearm) begin
        fill_r <= '0;
        seen_r <= '0;
      end
    end
  end

  // Replacement index: remainder, or raw output when the divisor wrapped to zero.
  assign j_val = wrap_r ? raw_r : rem_r;
  always_ff @(posedge clk) begin
    if (cmd.mul_b_hi) raw_r <= (acc_r + mul_p) ^ ((acc_r + mul_p) >> 31);
  end

  // Store write and read ports.
  always_comb begin
    wr_en   = cmd.fill_write;
    wr_addr = AW'(fill_r);
    if (cmd.repl_write && j_val < 64'(k_eff)) begin
      wr_en   = 1'b1;
      wr_addr = AW'(j_val);
    end
  end
  assign rd_addr = AW'(emit_r);

  rss_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (item_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_word.sample_value = rd_data;
  assign out_word.sample_slot  = 6'(emit_r);
  assign out_word.last_sample  = stat.emit_final;

`ifndef ASSERT_OFF
  // Fill never exceeds the built depth.
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(SLOT_COUNT))
    else $error("fill count overflow");
  // Emission stays below fill.
  a_emit_rng: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_out |-> emit_r < fill_r)
    else $error("emit beyond fill");
  // Divider never runs more than 64 steps.
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> div_cnt_r < 7'd64)
    else $error("divider overrun");
`endif

endmodule

[rtl/reservoir_sampler_splitmix.sv]
// Top level of the reservoir sampler.
//
// Usage: offer an item on in_word with start high while busy is low; it is
// taken at that edge. Configuration writes (cfg_we, cfg_idx, cfg_data) go to
// sample_size (index 0) or seed (index 1) and must be made while idle.
// During fill an item is latched, then stored in the next free slot. After
// fill, each item runs the generator through a 64-bit multiplier split
// into 32-bit halves and a radix-2 restoring divider of 64 steps; busy
// stays high until the item is done, so no new item is taken meanwhile.
// An item with last_item set is sampled, then every filled slot is emitted
// in slot order, each read from the store and then presented on the output,
// each marked by out_valid for a single cycle; the receiver cannot stall.
// last_sample flags the final slot. The block then re-arms: seen count and
// fill clear, and the seed reloads on the next stream's first item.
// Reset (rst_n low, synchronous) returns to idle with sample_size 16,
// seed 0 and an empty reservoir; no clearing pass is needed.
module reservoir_sampler_splitmix import rss_pkg::*; #(
  parameter int SLOT_COUNT = 16,
  parameter int ITEM_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  rss_in_t     in_word,
  output logic        out_valid,
  output rss_out_t    out_word,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [63:0] cfg_data
);

  rss_cmd_t  cmd;
  rss_stat_t stat;

  rss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_item (in_word.last_item),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  rss_dp #(.SLOT_COUNT(SLOT_COUNT), .ITEM_BITS(ITEM_BITS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_word  (in_word),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .out_word (out_word)
  );

  assign out_valid = cmd.emit_out;

endmodule

[test/tb.sv]
// Testbench for the reservoir sampler: directed table, then random streams.
`timescale 1ns / 100ps

module tb;
  import rss_pkg::*;

  localparam int SLOTS      = 16;
  localparam int CYC_LIMIT  = 400000;
  localparam int SETTLE_CYC = 100;

  typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [0:0]  idx;
    logic [63:0] data;      // item word or register value
    logic        last;
    logic        chk;       // first emitted word is typed in below
    logic [31:0] first_val;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  rss_in_t     in_word;
  logic        out_valid;
  rss_out_t    out_word;
  logic        cfg_we;
  logic [0:0]  cfg_idx;
  logic [63:0] cfg_data;

  // sampler model state
  logic [6:0]  mdl_size;
  logic [63:0] mdl_seed;
  logic [31:0] mdl_store [SLOTS];
  int unsigned mdl_fill;
  logic [63:0] mdl_seen;
  logic [63:0] mdl_gen;

  // first word and count of the latest emitted stream
  logic [31:0] first_emit;
  int unsigned emit_count;

  rss_out_t    pending_samples [$];
  int          errors;
  int          cycles;
  int          results_seen;
  int          streams_done;
  int          items_sent;
  int          idle_pct;

  reservoir_sampler_splitmix dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic logic [63:0] splitmix_next();
    logic [63:0] z;
    mdl_gen = mdl_gen + GOLDEN_STEP;
    z = mdl_gen;
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  // Sample one word into the model reservoir and queue any emitted slots.
  task automatic sample_word(input rss_in_t w);
    int unsigned k;
    int unsigned n;
    logic [63:0] r;
    logic [63:0] dv;
    logic [63:0] j;
    rss_out_t    o;
    k = (mdl_size > SLOTS) ? SLOTS : mdl_size;
    if (mdl_seen == 0) mdl_gen = mdl_seed;
    if (mdl_fill < k) begin
      mdl_store[mdl_fill] = w.item_value;
      mdl_fill++;
    end else begin
      r  = splitmix_next();
      dv = mdl_seen + 64'd1;
      j  = (dv == 0) ? r : r % dv;
      if (j < k) mdl_store[j] = w.item_value;
    end
    mdl_seen++;
    if (w.last_item) begin
      n = (mdl_fill > SLOTS) ? SLOTS : mdl_fill;
      emit_count = n;
      first_emit = mdl_store[0];
      for (int i = 0; i < n; i++) begin
        o.sample_value = mdl_store[i];
        o.sample_slot  = 6'(i);
        o.last_sample  = (i + 1 == n);
        pending_samples.insert(pending_samples.size(), o);
      end
      mdl_fill = 0;
      mdl_seen = 0;
      mdl_gen  = mdl_seed;
      streams_done++;
    end
  endtask

  // Offer one word; start stays high afterward unless a random idle gap is drawn.
  task automatic send_word(input logic [31:0] v, input logic last);
    rss_in_t w;
    w.item_value = v;
    w.last_item  = last;
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    sample_word(w);
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Write a register once the block has drained and settled.
  task automatic write_reg(input logic [0:0] idx, input logic [63:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    if (idx == CFG_SAMPLE_SIZE) mdl_size = val[6:0];
    else mdl_seed = val;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'hFFFF_FFFF;
      1: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6:0] pick_size();
    case ($urandom_range(6))
      0: return 7'd1;
      1: return 7'd16;
      2: return 7'd64;
      3: return 7'd127;
      4: return 7'd0;
      default: return 7'($urandom_range(2, 20));
    endcase
  endfunction

  // Check each emitted slot against the oldest expectation.
  always @(posedge clk) begin
    rss_out_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_samples.size() == 0) begin
        report($sformatf("unexpected slot %0d value %h",
                         out_word.sample_slot, out_word.sample_value));
      end else begin
        e = pending_samples.pop_front();
        if (out_word.sample_value !== e.sample_value)
          report($sformatf("slot %0d value %h, want %h", e.sample_slot,
                           out_word.sample_value, e.sample_value));
        if (out_word.sample_slot !== e.sample_slot)
          report($sformatf("slot index %0d, want %0d",
                           out_word.sample_slot, e.sample_slot));
        if (out_word.last_sample !== e.last_sample)
          report($sformatf("slot %0d last flag %b, want %b", e.sample_slot,
                           out_word.last_sample, e.last_sample));
      end
    end
    if (cycles > CYC_LIMIT) begin
      $display("timeout with %0d slots outstanding", pending_samples.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    row_t        dir_rows [$];
    int          len;
    int          phase_items;
    dir_rows = '{
      '{ROW_ITEM, 1'b0, 64'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'h0,         1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'hA5A5_A5A5, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{ROW_CFG,  CFG_SAMPLE_SIZE, 64'd1, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'h1234_5678, 1'b1, 1'b1, 32'h1234_5678},
      '{ROW_ITEM, 1'b0, 64'h1,         1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'h2,         1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'h3,         1'b1, 1'b0, 32'h0},
      '{ROW_CFG,  CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_CFG,  CFG_SAMPLE_SIZE, 64'd2, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'h8000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'h5555_5555, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'h0F0F_0F0F, 1'b1, 1'b0, 32'h0},
      // zero size: stores nothing, emits nothing
      '{ROW_CFG,  CFG_SAMPLE_SIZE, 64'd0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'hDEAD_BEEF, 1'b1, 1'b0, 32'h0},
      // size lowered mid-stream: filled slots still emitted
      '{ROW_CFG,  CFG_SAMPLE_SIZE, 64'd4, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'hCAFE_0001, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'hCAFE_0002, 1'b0, 1'b0, 32'h0},
      '{ROW_CFG,  CFG_SAMPLE_SIZE, 64'd1, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'hCAFE_0003, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'hCAFE_0004, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, 1'b0, 64'hCAFE_0005, 1'b1, 1'b0, 32'h0}
    };

    rst_n    = 1'b0;
    start    = 1'b0;
    in_word  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_SAMPLE_SIZE;
    cfg_data = '0;
    errors = 0; cycles = 0; results_seen = 0; streams_done = 0; items_sent = 0;
    idle_pct = 9;
    first_emit = '0; emit_count = 0;
    mdl_size = 7'd16; mdl_seed = '0; mdl_fill = 0; mdl_seen = '0; mdl_gen = '0;
    foreach (mdl_store[i]) mdl_store[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        emit_count = 0;
        send_word(dir_rows[r].data[31:0], dir_rows[r].last);
        if (dir_rows[r].chk && (emit_count == 0 ||
            first_emit !== dir_rows[r].first_val))
          report($sformatf("table row %0d: model disagrees with typed value", r));
      end
    end

    // random streams under three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 9 : (ph == 1) ? 83 : 0;
      phase_items = 0;
      while (phase_items < 55) begin
        if ($urandom_range(2) != 0) write_reg(CFG_SAMPLE_SIZE, 64'(pick_size()));
        if ($urandom_range(1) != 0) write_reg(CFG_SEED, {$urandom, $urandom});
        len = ($urandom_range(9) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 20);
        for (int i = 0; i < len; i++) send_word(pick_value(), i == len - 1);
        phase_items += len;
      end
    end

    // drain
    start <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d words in %0d streams; %0d slots checked.",
             items_sent, streams_done, results_seen);
    $display("Covered sizes 0..127 incl. saturation, extreme seeds, mid-stream resize.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
